// ===== rtl/core/twhm_pkg.sv =====
// ----------------------------------------------------------------------------
// twhm_pkg: shared types and constants of the time-window hit merger
// Beat formats, cell chain types, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package twhm_pkg;

    // table depth, one cell per entry
    localparam int MAX_HITS = 32;
    // wide enough to hold MAX_HITS itself
    localparam int COUNT_W = $clog2(MAX_HITS + 1);
    // fixed width of the entry_count field on the output beat
    localparam int ENTRY_COUNT_W = 6;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_RESOLUTION  = CFG_INDEX_W'(1);

    localparam logic [31:0] THRESHOLD_RESET  = 32'd10000; // 10 keV in eV
    localparam logic [31:0] RESOLUTION_RESET = 32'd300;   // 30 ns in 0.1 ns

    localparam logic OP_DEPOSIT   = 1'b0;
    localparam logic OP_END_EVENT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] sensor_number;
        logic [31:0] arrival_time;
        logic [31:0] deposit_energy;
    } in_beat_t;

    typedef struct packed {
        logic                     is_trailer;
        logic [15:0]              hit_sensor;
        logic [31:0]              hit_energy;
        logic [31:0]              hit_time;
        logic [31:0]              event_number;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     overflowed;
        logic                     last;
    } out_beat_t;

    // deposit walking down the cell chain
    typedef struct packed {
        logic        valid;
        logic        done;     // merged or appended
        logic        tried;    // first entry on this sensor already tested
        logic        appended; // opened a new entry
        logic [15:0] sensor;
        logic [31:0] stamp;
        logic [31:0] energy;
    } token_t;

    // one table entry held by one cell
    typedef struct packed {
        logic        occupied;
        logic [15:0] sensor;
        logic [31:0] energy;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic        shift;      // move every entry one cell toward the head
        logic [31:0] resolution; // merge window
    } cell_ctrl_t;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] count;
    } ctrl_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } ctrl_state_t;

endpackage

// ===== rtl/core/twhm_cell.sv =====
// ----------------------------------------------------------------------------
// twhm_cell: one table entry of the hit merger
// Tests a passing deposit against its entry, merges or appends, and shifts
// its entry toward the head during readout.
// ----------------------------------------------------------------------------
module twhm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  twhm_pkg::cell_ctrl_t ctrl,
    input  twhm_pkg::token_t     tok_in,
    output twhm_pkg::token_t     tok_out,
    input  twhm_pkg::entry_t     nbr_in,
    output twhm_pkg::entry_t     entry
);
    import twhm_pkg::*;

    entry_t      entry_reg, entry_next;
    token_t      tok_reg, tok_next;
    logic        sensor_hit;
    logic        time_ge;
    logic [31:0] time_diff;
    logic        in_window;
    logic [32:0] energy_sum;

    always_comb
    begin
        sensor_hit = entry_reg.sensor == tok_in.sensor;
        time_ge    = tok_in.stamp >= entry_reg.stamp;
        time_diff  = time_ge ? (tok_in.stamp - entry_reg.stamp)
                             : (entry_reg.stamp - tok_in.stamp);
        in_window  = time_diff < ctrl.resolution;
        energy_sum = {1'b0, entry_reg.energy} + {1'b0, tok_in.energy};

        entry_next = entry_reg;
        tok_next   = tok_in;

        if (ctrl.shift)
        begin
            entry_next = nbr_in;
        end
        else if (tok_in.valid && !tok_in.done)
        begin
            if (!entry_reg.occupied)
            begin
                // first free cell: open a new entry
                entry_next.occupied = 1'b1;
                entry_next.sensor   = tok_in.sensor;
                entry_next.energy   = tok_in.energy;
                entry_next.stamp    = tok_in.stamp;
                tok_next.done       = 1'b1;
                tok_next.appended   = 1'b1;
            end
            else if (sensor_hit && !tok_in.tried)
            begin
                if (in_window)
                begin
                    // saturate the sum
                    entry_next.energy = energy_sum[32] ? '1 : energy_sum[31:0];
                    tok_next.done     = 1'b1;
                end
                else
                begin
                    tok_next.tried = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign entry   = entry_reg;

endmodule

// ===== rtl/core/twhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// twhm_ctrl: sequencer and output register of the hit merger
// Injects deposits into the cell chain, tracks count and overflow, and
// drains the chain into result beats followed by the trailer.
// ----------------------------------------------------------------------------
module twhm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  twhm_pkg::in_beat_t     in_beat,
    output logic                   out_valid,
    input  logic                   out_stall,
    output twhm_pkg::out_beat_t    out_beat,
    input  logic [31:0]            threshold,
    input  twhm_pkg::entry_t       head,
    input  twhm_pkg::token_t       tok_exit,
    output twhm_pkg::token_t       tok_inject,
    output logic                   shift,
    output twhm_pkg::ctrl_status_t status
);
    import twhm_pkg::*;

    ctrl_state_t        state_reg, state_next;
    token_t             tok_reg, tok_next;
    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_beat_reg, out_beat_next;
    logic [31:0]        event_counter_reg, event_counter_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               overflow_reg, overflow_next;
    logic               accept;
    logic               out_free;

    always_comb
    begin
        state_next         = state_reg;
        tok_next           = '0;
        out_valid_next     = out_valid_reg;
        out_beat_next      = out_beat_reg;
        event_counter_next = event_counter_reg;
        count_next         = count_reg;
        overflow_next      = overflow_reg;
        shift              = 1'b0;

        in_stall = state_reg != ST_IDLE;
        accept   = in_valid && !in_stall;
        out_free = !out_valid_reg || !out_stall;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_beat.opcode == OP_END_EVENT)
                    begin
                        event_counter_next = event_counter_reg + 32'd1;
                        state_next         = ST_DRAIN;
                    end
                    else if (in_beat.deposit_energy != '0)
                    begin
                        tok_next.valid  = 1'b1;
                        tok_next.sensor = in_beat.sensor_number;
                        tok_next.stamp  = in_beat.arrival_time;
                        tok_next.energy = in_beat.deposit_energy;
                        state_next      = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (tok_exit.valid)
                begin
                    if (tok_exit.appended)
                    begin
                        count_next = COUNT_W'(count_reg + 1'b1);
                    end
                    if (!tok_exit.done)
                    begin
                        overflow_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_DRAIN:
            begin
                if (out_free)
                begin
                    if (head.occupied)
                    begin
                        // advance the chain; drop entries below threshold
                        shift = 1'b1;
                        if (head.energy >= threshold)
                        begin
                            out_valid_next             = 1'b1;
                            out_beat_next.is_trailer   = 1'b0;
                            out_beat_next.hit_sensor   = head.sensor;
                            out_beat_next.hit_energy   = head.energy;
                            out_beat_next.hit_time     = head.stamp;
                            out_beat_next.event_number = event_counter_reg;
                            out_beat_next.entry_count  = '0;
                            out_beat_next.overflowed   = 1'b0;
                            out_beat_next.last         = 1'b0;
                        end
                    end
                    else
                    begin
                        out_valid_next             = 1'b1;
                        out_beat_next.is_trailer   = 1'b1;
                        out_beat_next.hit_sensor   = '0;
                        out_beat_next.hit_energy   = '0;
                        out_beat_next.hit_time     = '0;
                        out_beat_next.event_number = event_counter_reg;
                        out_beat_next.entry_count  = ENTRY_COUNT_W'(count_reg);
                        out_beat_next.overflowed   = overflow_reg;
                        out_beat_next.last         = 1'b1;
                        count_next                 = '0;
                        overflow_next              = 1'b0;
                        state_next                 = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            tok_reg           <= '0;
            out_valid_reg     <= 1'b0;
            event_counter_reg <= '0;
            count_reg         <= '0;
            overflow_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            tok_reg           <= tok_next;
            out_valid_reg     <= out_valid_next;
            event_counter_reg <= event_counter_next;
            count_reg         <= count_next;
            overflow_reg      <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign tok_inject   = tok_reg;
    assign out_valid    = out_valid_reg;
    assign out_beat     = out_beat_reg;
    assign status.busy  = state_reg != ST_IDLE;
    assign status.count = count_reg;

endmodule

// ===== rtl/core/time_window_hit_merger_top.sv =====
// ----------------------------------------------------------------------------
// time_window_hit_merger_top: merges energy deposits into per-sensor hits
// Configuration registers, the sequencer and the chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry either a deposit (sensor, time, energy) or an end of
//   event. A deposit walks down a chain of MAX_HITS cells, one cell per
//   cycle; the first cell on the same sensor merges it when the time lies
//   inside the window, the first free cell opens a new hit, and a deposit
//   that leaves the chain unplaced sets the overflow flag. Zero-energy
//   deposits are taken and do nothing.
//   A deposit holds in_stall high from when it is taken until it leaves
//   the chain, so no new beat is taken while a deposit walks.
//   End of event shifts the chain toward its head, one entry per cycle
//   while the output register is free, and emits a beat for each entry at
//   or above the threshold, then the trailer (last = 1) with event number,
//   entry count and overflow flag.
//   A single output register holds a beat while out_stall is high; the
//   readout pauses behind it, and new input is taken once it is idle.
//   Reset empties the table, clears the event counter and the overflow
//   flag, and loads the threshold (10000 eV) and window (300 x 0.1 ns).
//   Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module time_window_hit_merger_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  twhm_pkg::in_beat_t                   in_beat,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output twhm_pkg::out_beat_t                  out_beat,
    input  logic                                 cfg_we,
    input  logic [twhm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [twhm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import twhm_pkg::*;

    logic [31:0]   threshold_reg;
    logic [31:0]   resolution_reg;
    cell_ctrl_t    cell_ctrl;
    ctrl_status_t  status;
    logic          shift;
    token_t        tok_chain [MAX_HITS+1];
    entry_t        entries   [MAX_HITS+1];
    logic [MAX_HITS-1:0] occ_vec;
    logic [MAX_HITS-1:0] occ_inc;

    // configuration registers; an unknown index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            resolution_reg <= RESOLUTION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENERGY_THRESHOLD: threshold_reg  <= cfg_data[31:0];
                REG_TIME_RESOLUTION:  resolution_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    twhm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_beat    (in_beat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_beat   (out_beat),
        .threshold  (threshold_reg),
        .head       (entries[0]),
        .tok_exit   (tok_chain[MAX_HITS]),
        .tok_inject (tok_chain[0]),
        .shift      (shift),
        .status     (status)
    );

    assign cell_ctrl.shift      = shift;
    assign cell_ctrl.resolution = resolution_reg;

    // the tail cell pulls in an empty entry during readout
    assign entries[MAX_HITS] = '0;

    for (genvar g = 0; g < MAX_HITS; g++)
    begin : g_cell
        twhm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1]),
            .nbr_in  (entries[g+1]),
            .entry   (entries[g])
        );
        assign occ_vec[g] = entries[g].occupied;
    end

    assign occ_inc = occ_vec + MAX_HITS'(1);

    // occupied cells always form one run starting at the head
    a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_inc & occ_vec) == '0)
        else $error("occupied cells are not contiguous from the head");

    // the entry count tracks the occupied cells whenever the block is idle
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> ($countones(occ_vec) == int'(status.count)))
        else $error("entry count disagrees with occupied cells");

    // a deposit leaves the chain only while input is held off
    a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[MAX_HITS].valid |-> in_stall)
        else $error("deposit left the chain while input was open");

    // a trailer leaves the table empty
    a_trailer_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_beat.is_trailer && !$past(out_valid)) |-> occ_vec == '0)
        else $error("table not empty after trailer");

endmodule

// ===== dv/tb_time_window_hit_merger_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_window_hit_merger_top: self-checking bench of the hit merger
// Feeds deposit and end-of-event beats through the valid/stall channel,
// mirrors the merge table in a local predictor and compares every output
// beat, field by field, against the oldest predicted record. Runs a directed
// block, then random event streams under several register settings.
// ----------------------------------------------------------------------------
module tb_time_window_hit_merger_top;
    import twhm_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int QUIET_LIMIT  = 5000;             // cycles with no beat taken
    localparam int SETTLE_TICKS = 2 * MAX_HITS + 8; // deposit walk plus margin
    localparam int MAX_SHOWN    = 10;
    localparam int PHASE_ITEMS  = 120;              // items per random phase, four phases

    typedef enum int {
        GEN_CLUSTER,
        GEN_FULL,
        GEN_NOISE
    } gen_kind_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_beat_t               in_beat = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_beat_t              out_beat;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    time_window_hit_merger_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the hit table, event state and registers.
    logic [15:0] tbl_sensor [MAX_HITS];
    logic [31:0] tbl_energy [MAX_HITS];
    logic [31:0] tbl_time   [MAX_HITS];
    int          tbl_count;
    logic [31:0] evt_ctr;
    logic        ovf_flag;
    logic [31:0] thr_reg;
    logic [31:0] win_reg;

    in_beat_t  beat_q[$];        // beats waiting for the driver
    out_beat_t hit_records_q[$]; // predicted output beats, oldest first
    out_beat_t want_rec;

    int   mismatch_count = 0;
    int   pushed_items = 0;      // beats that do something (zero energy excluded)
    int   idle_pct = 29;
    int   quiet_cycles = 0;
    logic beat_taken = 1'b0;

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Merge one deposit into the table: try only the first entry on the
    // same sensor, append otherwise, flag overflow when the table is full.
    function automatic void merge_deposit(in_beat_t b);
        int          slot;
        int          i;
        logic [31:0] gap;
        logic [32:0] sum;
        slot = -1;
        if (b.deposit_energy == 32'd0)
            return;
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_sensor[i] == b.sensor_number) begin
                slot = i;
                break;
            end
        end
        if (slot >= 0) begin
            gap = (b.arrival_time > tbl_time[slot]) ? b.arrival_time - tbl_time[slot]
                                                    : tbl_time[slot] - b.arrival_time;
            if (gap < win_reg) begin
                sum = {1'b0, tbl_energy[slot]} + {1'b0, b.deposit_energy};
                tbl_energy[slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                return;
            end
        end
        if (tbl_count >= MAX_HITS) begin
            ovf_flag = 1'b1;
            return;
        end
        tbl_sensor[tbl_count] = b.sensor_number;
        tbl_energy[tbl_count] = b.deposit_energy;
        tbl_time[tbl_count]   = b.arrival_time;
        tbl_count++;
    endfunction

    // End of event: queue every hit at or above threshold, then the trailer.
    function automatic void close_event();
        out_beat_t r;
        int        i;
        evt_ctr = evt_ctr + 32'd1;
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_energy[i] >= thr_reg) begin
                r = '0;
                r.hit_sensor   = tbl_sensor[i];
                r.hit_energy   = tbl_energy[i];
                r.hit_time     = tbl_time[i];
                r.event_number = evt_ctr;
                hit_records_q.push_back(r);
            end
        end
        r = '0;
        r.is_trailer   = 1'b1;
        r.event_number = evt_ctr;
        r.entry_count  = ENTRY_COUNT_W'(tbl_count);
        r.overflowed   = ovf_flag;
        r.last         = 1'b1;
        hit_records_q.push_back(r);
        tbl_count = 0;
        ovf_flag  = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic void push_beat(logic op, logic [15:0] s, logic [31:0] t,
                                      logic [31:0] e);
        in_beat_t b;
        b.opcode         = op;
        b.sensor_number  = s;
        b.arrival_time   = t;
        b.deposit_energy = e;
        beat_q.push_back(b);
        if (op == OP_END_EVENT || e != 32'd0)
            pushed_items++;
    endfunction

    // Mostly modest energies, with some zeros, full-range and near-max values
    // so that saturation and the extreme thresholds are reached.
    function automatic logic [31:0] pick_energy();
        logic [31:0] e;
        case ($urandom_range(0, 9))
            0:       e = 32'd0;
            1:       e = $urandom;
            2:       e = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            default: e = $urandom_range(1, 20000);
        endcase
        return e;
    endfunction

    function automatic void gen_event(gen_kind_t kind);
        logic [15:0] sens [4];
        logic [15:0] s0;
        logic [31:0] base;
        logic [31:0] t0;
        int          spread;
        int          nsens;
        int          n;
        int          j;
        case (kind)
            GEN_CLUSTER: begin
                // Few sensors, times bunched around a base so merges happen.
                base = $urandom;
                case ($urandom_range(0, 2))
                    0:       spread = 20;
                    1:       spread = 300;
                    default: spread = 3000;
                endcase
                nsens = $urandom_range(1, 4);
                for (j = 0; j < 4; j++)
                    sens[j] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 15));
                n = $urandom_range(1, 12);
                for (j = 0; j < n; j++)
                    push_beat(OP_DEPOSIT, sens[$urandom_range(0, nsens - 1)],
                              base + $urandom_range(0, 2 * spread) - spread,
                              pick_energy());
                push_beat(OP_END_EVENT, 16'($urandom), $urandom, $urandom);
            end
            GEN_FULL: begin
                // Fill the table with distinct sensors, spill a few, then hit
                // the first entry again so a merge lands on a full table.
                s0 = 16'($urandom);
                t0 = $urandom;
                n  = MAX_HITS + $urandom_range(1, 6);
                push_beat(OP_DEPOSIT, s0, t0, $urandom_range(1, 50000));
                for (j = 1; j < n; j++)
                    push_beat(OP_DEPOSIT, s0 + 16'(j), $urandom, $urandom_range(1, 50000));
                push_beat(OP_DEPOSIT, s0, t0, $urandom_range(1, 50000));
                push_beat(OP_END_EVENT, 16'($urandom), $urandom, $urandom);
            end
            default: begin
                push_beat(1'($urandom_range(0, 1)), 16'($urandom), $urandom,
                          ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Hold until every queued beat is taken and every record has come back,
    // then give a pending deposit walk time to finish.
    task automatic settle();
        while (beat_q.size() != 0 || hit_records_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Register write; the block is idle, so update the local copy right away.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_ENERGY_THRESHOLD)
            thr_reg = val;
        else if (idx == REG_TIME_RESOLUTION)
            win_reg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int quota, input bit lead_full);
        int start;
        int r;
        start = pushed_items;
        if (lead_full)
            gen_event(GEN_FULL);
        while (pushed_items - start < quota) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                gen_event(GEN_FULL);
            else if (r < 85)
                gen_event(GEN_CLUSTER);
            else
                gen_event(GEN_NOISE);
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Input driver: change at the falling edge, hold a stalled beat
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || beat_taken) begin
            // previous beat gone (or none): offer the next one, or idle
            if (beat_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                in_valid <= 1'b1;
                in_beat  <= beat_q[0];
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, drawn fresh each cycle.
    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge; check output before predicting
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        beat_taken <= rst_n && in_valid && !in_stall;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (hit_records_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("unexpected output beat: %p", out_beat);
                end
                else begin
                    want_rec = hit_records_q.pop_front();
                    if (out_beat.is_trailer   !== want_rec.is_trailer   ||
                        out_beat.hit_sensor   !== want_rec.hit_sensor   ||
                        out_beat.hit_energy   !== want_rec.hit_energy   ||
                        out_beat.hit_time     !== want_rec.hit_time     ||
                        out_beat.event_number !== want_rec.event_number ||
                        out_beat.entry_count  !== want_rec.entry_count  ||
                        out_beat.overflowed   !== want_rec.overflowed   ||
                        out_beat.last         !== want_rec.last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN) begin
                            $display("mismatch want: trl=%0d sns=%h en=%h tm=%h ev=%h cnt=%0d ovf=%0d last=%0d",
                                     want_rec.is_trailer, want_rec.hit_sensor,
                                     want_rec.hit_energy, want_rec.hit_time,
                                     want_rec.event_number, want_rec.entry_count,
                                     want_rec.overflowed, want_rec.last);
                            $display("         got:  trl=%0d sns=%h en=%h tm=%h ev=%h cnt=%0d ovf=%0d last=%0d",
                                     out_beat.is_trailer, out_beat.hit_sensor,
                                     out_beat.hit_energy, out_beat.hit_time,
                                     out_beat.event_number, out_beat.entry_count,
                                     out_beat.overflowed, out_beat.last);
                        end
                    end
                end
            end
            if (in_valid && !in_stall) begin
                // advance the predictor on the beat the block just took
                if (in_beat.opcode == OP_DEPOSIT)
                    merge_deposit(in_beat);
                else
                    close_event();
                void'(beat_q.pop_front());
            end
        end
    end

    // Watchdog: too long without any beat moving on either channel.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        thr_reg   = THRESHOLD_RESET;
        win_reg   = RESOLUTION_RESET;
        tbl_count = 0;
        evt_ctr   = 32'd0;
        ovf_flag  = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed block at reset values (threshold 10000, window 300).
        push_beat(OP_DEPOSIT, 16'd5, 32'd100, 32'd0);               // zero energy: drop
        push_beat(OP_END_EVENT, 16'd0, 32'd0, 32'd0);               // empty event
        push_beat(OP_DEPOSIT, 16'h0000, 32'd0, 32'hFFFF_FFFF);
        push_beat(OP_DEPOSIT, 16'h0000, 32'd299, 32'd7);            // merge, saturate
        push_beat(OP_DEPOSIT, 16'h0000, 32'd300, 32'd1);            // window edge: new hit
        push_beat(OP_DEPOSIT, 16'h0000, 32'd550, 32'd20000);        // first fails, later skipped
        push_beat(OP_DEPOSIT, 16'hFFFF, 32'hFFFF_FFFF, 32'd9999);
        push_beat(OP_DEPOSIT, 16'hFFFF, 32'hFFFF_FFFE, 32'd1);      // lands on threshold
        push_beat(OP_DEPOSIT, 16'h1234, 32'd5000, 32'd9999);        // just below threshold
        push_beat(OP_DEPOSIT, 16'hAAAA, 32'h5555_5555, 32'h5555_5555);
        push_beat(OP_DEPOSIT, 16'h5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        push_beat(OP_END_EVENT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_beat(OP_END_EVENT, 16'h0000, 32'd0, 32'd0);
        push_beat(OP_DEPOSIT, 16'd7, 32'd1000, 32'd10000);
        push_beat(OP_DEPOSIT, 16'd7, 32'd700, 32'd1);               // diff equals window
        push_beat(OP_DEPOSIT, 16'd7, 32'd701, 32'd1);               // merges into first
        push_beat(OP_DEPOSIT, 16'd7, 32'd1299, 32'd0);              // zero energy again
        push_beat(OP_END_EVENT, 16'd3, 32'd4, 32'd5);
        settle();

        // Report everything, widest window.
        write_reg(REG_ENERGY_THRESHOLD, 32'd0);
        write_reg(REG_TIME_RESOLUTION, 32'hFFFF_FFFF);
        run_random(PHASE_ITEMS, 1'b1);

        // Only saturated hits reported, nothing merges; no idling at all.
        idle_pct = 0;
        write_reg(REG_ENERGY_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(REG_TIME_RESOLUTION, 32'd0);
        run_random(PHASE_ITEMS, 1'b1);

        // Random mid-range setting.
        idle_pct = 29;
        write_reg(REG_ENERGY_THRESHOLD, $urandom_range(1000, 60000));
        write_reg(REG_TIME_RESOLUTION, $urandom_range(1, 2000));
        run_random(PHASE_ITEMS, 1'b0);

        // Back to the reset values, written explicitly.
        write_reg(REG_ENERGY_THRESHOLD, THRESHOLD_RESET);
        write_reg(REG_TIME_RESOLUTION, RESOLUTION_RESET);
        run_random(PHASE_ITEMS, 1'b0);

        if (mismatch_count == 0 && hit_records_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
